FILE: rtl/tsc_pkg.sv
// shared constants, types and helper functions of the taylor sine/cosine/tangent unit
`default_nettype none
package tsc_pkg;

	// function selector codes
	localparam logic [1:0] OP_SIN = 2'd0;
	localparam logic [1:0] OP_COS = 2'd1;
	localparam logic [1:0] OP_TAN = 2'd2;
	localparam logic [1:0] OP_COT = 2'd3;

	// internal widths, work format has 32 fraction bits
	localparam int PW  = 32;  // result code width
	localparam int XW  = 35;  // reduced angle magnitude, below two pi
	localparam int X2W = 38;  // square of the reduced angle
	localparam int TW  = 40;  // series term magnitude
	localparam int NW  = 46;  // rounded term product ahead of the constant division
	localparam int SW  = 44;  // signed series sum
	localparam int DW  = 12;  // series denominator
	localparam int MW  = 48;  // magnitude fed to the saturating pack
	localparam int QW  = 34;  // quotient bits of the tangent divider
	localparam int RW  = 45;  // divider remainder

	localparam logic [XW-1:0] TWO_PI = 35'h6487ED511;

	typedef struct packed {
		logic                 valid;
		logic [1:0]           sel;
		logic                 xneg;
		logic [X2W-1:0]       x2;
		logic [TW-1:0]        ts;
		logic [TW-1:0]        tc;
		logic signed [SW-1:0] ss;
		logic signed [SW-1:0] sc;
	} term_t;

	typedef struct packed {
		logic [PW-1:0] value;
		logic          ovf;
	} res_t;

	// denominator of the term recurrence for step i
	function automatic int unsigned denom(input int unsigned i, input bit is_sin);
		return is_sin ? (4 * i * i + 2 * i) : (4 * i * i - 2 * i);
	endfunction

	// sign and magnitude to a saturated two's complement code
	function automatic res_t pack(input logic neg, input logic [MW-1:0] mag);
		res_t          r;
		logic [MW-1:0] t;
		t = ~mag + MW'(1);
		r.ovf = 1'b0;
		if (neg) begin
			if (mag > MW'(64'h8000_0000)) begin
				r.value = 32'h8000_0000;
				r.ovf   = 1'b1;
			end else begin
				r.value = t[PW-1:0];
			end
		end else begin
			if (mag > MW'(64'h7FFF_FFFF)) begin
				r.value = 32'h7FFF_FFFF;
				r.ovf   = 1'b1;
			end else begin
				r.value = mag[PW-1:0];
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/tsc_req_if.sv
// request channel: function selector and angle
`default_nettype none
interface tsc_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic signed [31:0] angle;

	modport source(output valid, req_type, angle, input ready);
	modport sink(input valid, req_type, angle, output ready);
endinterface
`default_nettype wire

FILE: rtl/tsc_rsp_if.sv
// response channel: saturated result and overflow flag
`default_nettype none
interface tsc_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic               overflow;

	modport source(output valid, value, overflow, input ready);
	modport sink(input valid, value, overflow, output ready);
endinterface
`default_nettype wire

FILE: rtl/tsc_mul.sv
// two-stage multiplier built from four half-width partial products
`default_nettype none
module tsc_mul #(
	parameter int AW = 8,
	parameter int BW = 8
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [AW-1:0] a,
	input  wire logic [BW-1:0] b,
	output logic [AW+BW-1:0]   p
);
	localparam int AL = AW / 2;
	localparam int AH = AW - AL;
	localparam int BL = BW / 2;
	localparam int BH = BW - BL;
	localparam int PWD = AW + BW;

	logic [AL+BL-1:0] ll_s1;
	logic [AL+BH-1:0] lh_s1;
	logic [AH+BL-1:0] hl_s1;
	logic [AH+BH-1:0] hh_s1;

	// partial products
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= (AL+BL)'(a[AL-1:0]) * (AL+BL)'(b[BL-1:0]);
			lh_s1 <= (AL+BH)'(a[AL-1:0]) * (AL+BH)'(b[BW-1:BL]);
			hl_s1 <= (AH+BL)'(a[AW-1:AL]) * (AH+BL)'(b[BL-1:0]);
			hh_s1 <= (AH+BH)'(a[AW-1:AL]) * (AH+BH)'(b[BW-1:BL]);
		end
	end

	// recombine
	always_ff @(posedge clk) begin
		if (en) begin
			p <= (PWD'(hh_s1) << (AL + BL)) + (PWD'(lh_s1) << BL)
				+ (PWD'(hl_s1) << AL) + PWD'(ll_s1);
		end
	end
endmodule
`default_nettype wire

FILE: rtl/tsc_sub_cell.sv
// one compare-and-subtract step of a restoring reduction or division chain
`default_nettype none
module tsc_sub_cell #(
	parameter int RW      = 8,
	parameter int DVW     = 8,
	parameter int QBW     = 1,
	parameter int SDW     = 1,
	parameter int D_SHIFT = 0,
	parameter int R_SHIFT = 0
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  wire logic [RW-1:0]  in_r,
	input  wire logic [DVW-1:0] in_d,
	input  wire logic [QBW-1:0] in_q,
	input  wire logic [SDW-1:0] in_side,
	output logic                out_valid,
	output logic [RW-1:0]       out_r,
	output logic [DVW-1:0]      out_d,
	output logic [QBW-1:0]      out_q,
	output logic [SDW-1:0]      out_side
);
	localparam int CW = (RW + R_SHIFT > DVW + D_SHIFT) ? RW + R_SHIFT : DVW + D_SHIFT;

	logic [CW-1:0] rr;
	logic [CW-1:0] dd;
	logic [CW-1:0] diff;
	logic          ge;

	// trial subtraction
	always_comb begin
		rr   = CW'(in_r) << R_SHIFT;
		dd   = CW'(in_d) << D_SHIFT;
		ge   = rr >= dd;
		diff = rr - dd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_r    <= ge ? diff[RW-1:0] : rr[RW-1:0];
			out_d    <= in_d;
			out_q    <= QBW'({in_q, ge});
			out_side <= in_side;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/tsc_term_cell.sv
// one term of the sine and cosine series: next terms and running sums
`default_nettype none
module tsc_term_cell #(
	parameter int I = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire tsc_pkg::term_t in_t,
	output tsc_pkg::term_t     out_t
);
	localparam int NW = tsc_pkg::NW;
	localparam int TW = tsc_pkg::TW;
	localparam int SW = tsc_pkg::SW;
	localparam int X2W = tsc_pkg::X2W;
	localparam int CMW = TW + tsc_pkg::DW + 1;
	localparam int unsigned DS = tsc_pkg::denom(I, 1'b1);
	localparam int unsigned DC = tsc_pkg::denom(I, 1'b0);
	localparam logic [NW-1:0] MS = NW'((64'd1 << NW) / 64'(DS));
	localparam logic [NW-1:0] MC = NW'((64'd1 << NW) / 64'(DC));
	localparam logic [NW-1:0] HS = NW'(DS / 2);
	localparam logic [NW-1:0] HC = NW'(DC / 2);
	localparam logic ODD = 1'(I % 2);

	tsc_pkg::term_t    dly_s [0:5];
	logic [TW+X2W-1:0] ps;
	logic [TW+X2W-1:0] pc;
	logic [NW-1:0]     ns_s3, nc_s3, ns_s4, nc_s4, ns_s5, nc_s5;
	logic [2*NW-1:0]   pms;
	logic [2*NW-1:0]   pmc;
	logic [TW-1:0]     qs_s6, qc_s6;
	logic              ges_s6, gec_s6;
	logic [TW-1:0]     qs_new, qc_new;
	logic signed [SW-1:0] es, ec;
	logic              sneg;
	tsc_pkg::term_t    nxt;

	// term times x squared
	tsc_mul #(.AW(TW), .BW(X2W)) u_mul_ps (
		.clk(clk), .en(en), .a(in_t.ts), .b(in_t.x2), .p(ps)
	);
	tsc_mul #(.AW(TW), .BW(X2W)) u_mul_pc (
		.clk(clk), .en(en), .a(in_t.tc), .b(in_t.x2), .p(pc)
	);

	// quotient estimate through the reciprocal
	tsc_mul #(.AW(NW), .BW(NW)) u_mul_qs (
		.clk(clk), .en(en), .a(ns_s3), .b(MS), .p(pms)
	);
	tsc_mul #(.AW(NW), .BW(NW)) u_mul_qc (
		.clk(clk), .en(en), .a(nc_s3), .b(MC), .p(pmc)
	);

	// side data delay line, valid bits reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 6; k++) dly_s[k].valid <= 1'b0;
			out_t.valid <= 1'b0;
		end else if (en) begin
			dly_s[0] <= in_t;
			for (int k = 1; k < 6; k++) dly_s[k] <= dly_s[k-1];
			out_t <= nxt;
		end
	end

	// round product, add half denominator, quotient correction
	always_ff @(posedge clk) begin
		if (en) begin
			ns_s3  <= NW'(ps[TW+X2W-1:32]) + NW'(ps[31]) + HS;
			nc_s3  <= NW'(pc[TW+X2W-1:32]) + NW'(pc[31]) + HC;
			ns_s4  <= ns_s3;
			nc_s4  <= nc_s3;
			ns_s5  <= ns_s4;
			nc_s5  <= nc_s4;
			qs_s6  <= pms[NW +: TW];
			qc_s6  <= pmc[NW +: TW];
			ges_s6 <= (CMW'(pms[NW +: TW]) * CMW'(DS) + CMW'(DS)) <= CMW'(ns_s5);
			gec_s6 <= (CMW'(pmc[NW +: TW]) * CMW'(DC) + CMW'(DC)) <= CMW'(nc_s5);
		end
	end

	// new terms and sums, odd steps subtract
	always_comb begin
		qs_new = qs_s6 + TW'(ges_s6);
		qc_new = qc_s6 + TW'(gec_s6);
		es     = SW'({1'b0, qs_new});
		ec     = SW'({1'b0, qc_new});
		sneg   = dly_s[5].xneg ^ ODD;
		nxt    = dly_s[5];
		nxt.ts = qs_new;
		nxt.tc = qc_new;
		nxt.ss = dly_s[5].ss + (sneg ? -es : es);
		nxt.sc = dly_s[5].sc + (ODD ? -ec : ec);
	end
endmodule
`default_nettype wire

FILE: rtl/taylor_sin_cos_tan_unit.sv
// top level of the taylor-series sine, cosine, tangent and cotangent unit
// Usage:
//   req carries a function selector (sine, cosine, tangent, cotangent) and a
//   signed angle in radians with FRACTION_BITS fraction bits; rsp returns one
//   saturated result with the same fraction bits and an overflow flag per beat.
// Datapath: the angle is reduced modulo two pi by a row of compare-subtract
//   cells, squared, then passed along a row of SERIES_TERMS-1 term cells that
//   sum sine and cosine together; tangent and cotangent go on through a row of
//   34 restoring divider cells.
// Pipeline: the term cells, seven stages each, make up most of the stages
//   between an accepted request and its response beat.
// Throughput: one beat per cycle unless the pipeline stalls; every stage
//   moves on together.
// Stall: when the response register is full and rsp.ready is low the whole
//   pipeline holds and req.ready drops in the same cycle.
// Reset: arst_n clears all valid bits; no response is pending after reset.
`default_nettype none
module taylor_sin_cos_tan_unit #(
	parameter int SERIES_TERMS  = 16,
	parameter int FRACTION_BITS = 24
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tsc_req_if.sink     req,
	tsc_rsp_if.source   rsp
);
	localparam int SH    = 32 - FRACTION_BITS;
	localparam int VW    = 32 + SH;
	localparam int XW    = tsc_pkg::XW;
	localparam int X2W   = tsc_pkg::X2W;
	localparam int TW    = tsc_pkg::TW;
	localparam int SW    = tsc_pkg::SW;
	localparam int MW    = tsc_pkg::MW;
	localparam int QW    = tsc_pkg::QW;
	localparam int RW    = tsc_pkg::RW;
	localparam int NSTEP = (VW - 34 > 1) ? VW - 34 : 1;
	localparam int IB    = SH;
	localparam int SDW   = 5 + tsc_pkg::PW + 1;
	localparam int CKW   = SW + IB + 1;

	logic en;

	// global advance: response slot free or being taken
	logic out_valid_q;
	logic [tsc_pkg::PW-1:0] value_q;
	logic ovf_q;

	assign en        = !out_valid_q || rsp.ready;
	assign req.ready = en;

	// input stage: sign and magnitude of the angle
	logic        v_s1, neg_s1;
	logic [1:0]  sel_s1;
	logic [31:0] mag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sel_s1 <= req.req_type;
			neg_s1 <= req.angle[31];
			mag_s1 <= req.angle[31] ? (~req.angle + 32'sd1) : req.angle;
		end
	end

	// reduction row, remainder modulo two pi
	logic          m_v    [0:NSTEP];
	logic [VW-1:0] m_r    [0:NSTEP];
	logic [XW-1:0] m_d    [0:NSTEP];
	logic [2:0]    m_side [0:NSTEP];

	assign m_v[0]    = v_s1;
	assign m_r[0]    = VW'(mag_s1) << SH;
	assign m_d[0]    = tsc_pkg::TWO_PI;
	assign m_side[0] = {sel_s1, neg_s1};

	for (genvar j = 0; j < NSTEP; j++) begin : g_mod
		tsc_sub_cell #(
			.RW(VW), .DVW(XW), .QBW(1), .SDW(3),
			.D_SHIFT(NSTEP - 1 - j), .R_SHIFT(0)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(m_v[j]), .in_r(m_r[j]), .in_d(m_d[j]), .in_q(1'b0),
			.in_side(m_side[j]),
			.out_valid(m_v[j+1]), .out_r(m_r[j+1]), .out_d(m_d[j+1]), .out_q(),
			.out_side(m_side[j+1])
		);
	end

	// reduced angle, zero carries no sign
	logic          v_s2, v_s3, v_s4;
	logic          xneg_s2, xneg_s3, xneg_s4;
	logic [1:0]    sel_s2, sel_s3, sel_s4;
	logic [XW-1:0] xmag_s2, xmag_s3, xmag_s4;
	logic [2*XW-1:0] xp;
	tsc_pkg::term_t tchain [0:SERIES_TERMS-1];

	// valid pipe and first terms: x for sine, one for cosine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			tchain[0].valid <= 1'b0;
		end else if (en) begin
			v_s2 <= m_v[NSTEP];
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			tchain[0].valid <= v_s4;
			tchain[0].sel   <= sel_s4;
			tchain[0].xneg  <= xneg_s4;
			tchain[0].x2    <= X2W'(xp[2*XW-1:32]) + X2W'(xp[31]);
			tchain[0].ts    <= TW'(xmag_s4);
			tchain[0].tc    <= TW'(1) << 32;
			tchain[0].ss    <= xneg_s4 ? -SW'(xmag_s4) : SW'(xmag_s4);
			tchain[0].sc    <= SW'(1) << 32;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xmag_s2 <= m_r[NSTEP][XW-1:0];
			xneg_s2 <= m_side[NSTEP][0] && (m_r[NSTEP][XW-1:0] != '0);
			sel_s2  <= m_side[NSTEP][2:1];
			xmag_s3 <= xmag_s2;
			xneg_s3 <= xneg_s2;
			sel_s3  <= sel_s2;
			xmag_s4 <= xmag_s3;
			xneg_s4 <= xneg_s3;
			sel_s4  <= sel_s3;
		end
	end

	// x squared
	tsc_mul #(.AW(XW), .BW(XW)) u_mul_x2 (
		.clk(clk), .en(en), .a(xmag_s2), .b(xmag_s2), .p(xp)
	);

	// series row
	for (genvar i = 1; i < SERIES_TERMS; i++) begin : g_term
		tsc_term_cell #(.I(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_t(tchain[i-1]), .out_t(tchain[i])
		);
	end

	// operand selection and sine/cosine output rounding
	tsc_pkg::term_t       last;
	logic signed [SW-1:0] num, den, vsel;
	logic [SW-1:0]        vmag;
	logic [MW-1:0]        vrnd;
	tsc_pkg::res_t        tres;

	always_comb begin
		last = tchain[SERIES_TERMS-1];
		num  = (last.sel == tsc_pkg::OP_COT) ? last.sc : last.ss;
		den  = (last.sel == tsc_pkg::OP_COT) ? last.ss : last.sc;
		vsel = (last.sel == tsc_pkg::OP_COS) ? last.sc : last.ss;
		vmag = vsel[SW-1] ? SW'(-vsel) : SW'(vsel);
		vrnd = (MW'(vmag) + (MW'(1) << (SH - 1))) >> SH;
		tres = tsc_pkg::pack(vsel[SW-1], vrnd);
	end

	logic          v_da, v_db;
	logic          isdiv_da, qneg_da, nneg_da;
	logic [SW-1:0] nmag_da, dmag_da;
	tsc_pkg::res_t tres_da;
	logic [RW-1:0] nr_db;
	logic [SW-1:0] dmag_db;
	logic [SDW-1:0] side_db;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_da <= 1'b0;
			v_db <= 1'b0;
		end else if (en) begin
			v_da <= last.valid;
			v_db <= v_da;
		end
	end

	// quotient range check ahead of the divider row
	always_ff @(posedge clk) begin
		if (en) begin
			isdiv_da <= (last.sel == tsc_pkg::OP_TAN) || (last.sel == tsc_pkg::OP_COT);
			qneg_da  <= num[SW-1] ^ den[SW-1];
			nneg_da  <= num[SW-1];
			nmag_da  <= num[SW-1] ? SW'(-num) : SW'(num);
			dmag_da  <= den[SW-1] ? SW'(-den) : SW'(den);
			tres_da  <= tres;
			nr_db    <= RW'(nmag_da);
			dmag_db  <= dmag_da;
			side_db  <= {isdiv_da, qneg_da, nneg_da, dmag_da == '0,
				CKW'(nmag_da) >= ((CKW'(dmag_da) << IB) + CKW'(dmag_da)),
				tres_da.value, tres_da.ovf};
		end
	end

	// divider row: integer bits, then fraction bits plus a rounding bit
	logic           d_v    [0:QW];
	logic [RW-1:0]  d_r    [0:QW];
	logic [SW-1:0]  d_d    [0:QW];
	logic [QW-1:0]  d_q    [0:QW];
	logic [SDW-1:0] d_side [0:QW];

	assign d_v[0]    = v_db;
	assign d_r[0]    = nr_db;
	assign d_d[0]    = dmag_db;
	assign d_q[0]    = '0;
	assign d_side[0] = side_db;

	for (genvar k = 0; k < QW; k++) begin : g_div
		tsc_sub_cell #(
			.RW(RW), .DVW(SW), .QBW(QW), .SDW(SDW),
			.D_SHIFT((k <= IB) ? IB - k : 0), .R_SHIFT((k <= IB) ? 0 : 1)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(d_v[k]), .in_r(d_r[k]), .in_d(d_d[k]), .in_q(d_q[k]),
			.in_side(d_side[k]),
			.out_valid(d_v[k+1]), .out_r(d_r[k+1]), .out_d(d_d[k+1]), .out_q(d_q[k+1]),
			.out_side(d_side[k+1])
		);
	end

	// final selection and saturation
	logic [SDW-1:0] fs;
	logic [QW:0]    qr;
	tsc_pkg::res_t  fres;

	always_comb begin
		fs = d_side[QW];
		qr = ((QW+1)'(d_q[QW]) + (QW+1)'(1)) >> 1;
		if (!fs[SDW-1]) begin
			fres.value = fs[tsc_pkg::PW:1];
			fres.ovf   = fs[0];
		end else if (fs[SDW-4]) begin
			fres     = tsc_pkg::pack(fs[SDW-3], '1);
			fres.ovf = 1'b1;
		end else if (fs[SDW-5]) begin
			fres     = tsc_pkg::pack(fs[SDW-2], '1);
			fres.ovf = 1'b1;
		end else begin
			fres = tsc_pkg::pack(fs[SDW-2], MW'(qr));
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= d_v[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value_q <= fres.value;
			ovf_q   <= fres.ovf;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.value    = value_q;
	assign rsp.overflow = ovf_q;
endmodule
`default_nettype wire
